/* src/lbpm_pkg.sv */
// Shared types, codes and default sizes for the LRU buffer pool manager.
package lbpm_pkg;

	// Default sizes
	localparam int unsigned SlotsDef    = 32;
	localparam int unsigned DiskSizeDef = 8192;
	localparam int unsigned AgeBitsDef  = 16;

	// Fixed field widths
	localparam int unsigned OpW      = 2;
	localparam int unsigned BlkW     = 14;
	localparam int unsigned StatusW  = 2;
	localparam int unsigned SlotIdxW = 5;
	localparam int unsigned WbBlkW   = 13;

	// Request kinds
	localparam logic [OpW-1:0] OP_ALLOC  = 2'd0;
	localparam logic [OpW-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OpW-1:0] OP_DIRTY  = 2'd2;
	// Unused code, answered as a miss
	localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

	// Result status codes
	localparam logic [StatusW-1:0] ST_OK   = 2'd0;
	localparam logic [StatusW-1:0] ST_OOB  = 2'd1;
	localparam logic [StatusW-1:0] ST_MISS = 2'd2;

	// Flags carried by the search item along the chain
	typedef struct packed {
		logic match_found;
		logic free_found;
		logic best_dirty;
	} srch_flags_t;

	// Update broadcast to every cell at the end of a search
	typedef struct packed {
		logic age_all;
		logic install;
		logic mark;
	} cmt_ctl_t;

endpackage

/* src/lbpm_cell.sv */
// One buffer slot: its state plus one stage of the search chain.
module lbpm_cell #(
	parameter int unsigned CELL_IDX = 0,
	parameter int unsigned IDX_W    = 5,
	parameter int unsigned TAG_W    = 13,
	parameter int unsigned AGE_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// search item from the previous cell
	input  logic [TAG_W-1:0]        blk_in,
	input  lbpm_pkg::srch_flags_t   flags_in,
	input  logic [IDX_W-1:0]        match_idx_in,
	input  logic [IDX_W-1:0]        free_idx_in,
	input  logic [IDX_W-1:0]        best_idx_in,
	input  logic [AGE_BITS-1:0]     best_age_in,
	input  logic [TAG_W-1:0]        best_tag_in,
	// search item to the next cell
	output logic [TAG_W-1:0]        blk_out,
	output lbpm_pkg::srch_flags_t   flags_out,
	output logic [IDX_W-1:0]        match_idx_out,
	output logic [IDX_W-1:0]        free_idx_out,
	output logic [IDX_W-1:0]        best_idx_out,
	output logic [AGE_BITS-1:0]     best_age_out,
	output logic [TAG_W-1:0]        best_tag_out,
	// broadcast update
	input  lbpm_pkg::cmt_ctl_t      cmt,
	input  logic [IDX_W-1:0]        cmt_idx,
	input  logic [TAG_W-1:0]        cmt_tag
);
	import lbpm_pkg::*;

	localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

	logic                valid_q;
	logic                dirty_q;
	logic [TAG_W-1:0]    tag_q;
	logic [AGE_BITS-1:0] age_q;

	logic [AGE_BITS-1:0] aged;
	logic                hit;
	logic                take_best;
	logic                sel;

	logic [TAG_W-1:0]    blk_q;
	srch_flags_t         flags_q;
	logic [IDX_W-1:0]    match_idx_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic [AGE_BITS-1:0] best_age_q;
	logic [TAG_W-1:0]    best_tag_q;

	// Age as it will be once the allocate ages occupied slots (saturating)
	always_comb begin
		aged = age_q;
		if (valid_q && (age_q != '1)) begin
			aged = age_q + AGE_BITS'(1);
		end
	end

	assign hit       = valid_q && (tag_q == blk_in);
	assign take_best = (CELL_IDX == 0) || (aged > best_age_in);
	assign sel       = (cmt_idx == MyIdx);

	// Advance the search item by one cell
	always_ff @(posedge clk) begin
		blk_q                <= blk_in;
		flags_q.match_found  <= flags_in.match_found | hit;
		match_idx_q          <= flags_in.match_found ? match_idx_in : MyIdx;
		flags_q.free_found   <= flags_in.free_found | ~valid_q;
		free_idx_q           <= flags_in.free_found ? free_idx_in : MyIdx;
		flags_q.best_dirty   <= take_best ? dirty_q : flags_in.best_dirty;
		best_idx_q           <= take_best ? MyIdx : best_idx_in;
		best_age_q           <= take_best ? aged : best_age_in;
		best_tag_q           <= take_best ? tag_q : best_tag_in;
	end

	assign blk_out       = blk_q;
	assign flags_out     = flags_q;
	assign match_idx_out = match_idx_q;
	assign free_idx_out  = free_idx_q;
	assign best_idx_out  = best_idx_q;
	assign best_age_out  = best_age_q;
	assign best_tag_out  = best_tag_q;

	// Hold slot flags and age; apply ageing, install and mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dirty_q <= 1'b0;
			age_q   <= '0;
		end else begin
			if (cmt.age_all) begin
				age_q <= aged;
			end
			if (cmt.install && sel) begin
				valid_q <= 1'b1;
				dirty_q <= 1'b0;
				age_q   <= '0;
			end else if (cmt.mark && sel) begin
				dirty_q <= 1'b1;
			end
		end
	end

	// Tag is written only on install
	always_ff @(posedge clk) begin
		if (cmt.install && sel) begin
			tag_q <= cmt_tag;
		end
	end

endmodule

/* src/lru_buffer_pool_manager_unit.sv */
// One search sweep per item: the request walks down the row of slot cells (one cell per
// cycle), then the update state stores the result once the output register is free.
// A new item is accepted only after that, back in the idle state.
// A finished result waits in the output register while the next item is searched.
// Reset (arst_n low, asynchronous): all slots free and clean, ages zero, no result held.
module lru_buffer_pool_manager_unit #(
	parameter int unsigned SLOTS     = lbpm_pkg::SlotsDef,
	parameter int unsigned DISK_SIZE = lbpm_pkg::DiskSizeDef,
	parameter int unsigned AGE_BITS  = lbpm_pkg::AgeBitsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [13:0] block_number
	input  logic [1:0]  s_tuser,  // [1:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // [1:0] status, [6:2] slot_index,
	                              // [7] writeback_valid, [20:8] writeback_block
);
	import lbpm_pkg::*;

	localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned TAG_W = (DISK_SIZE > 1) ? $clog2(DISK_SIZE) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_COMMIT
	} state_t;

	state_t              state_q;
	logic [IDX_W-1:0]    cnt_q;
	logic [OpW-1:0]      op_q;
	logic [BlkW-1:0]     blk_q;
	logic                out_valid_q;
	logic [23:0]         out_data_q;

	// Chain wiring, one entry per cell boundary
	logic [TAG_W-1:0]    c_blk       [SLOTS+1];
	srch_flags_t         c_flags     [SLOTS+1];
	logic [IDX_W-1:0]    c_match_idx [SLOTS+1];
	logic [IDX_W-1:0]    c_free_idx  [SLOTS+1];
	logic [IDX_W-1:0]    c_best_idx  [SLOTS+1];
	logic [AGE_BITS-1:0] c_best_age  [SLOTS+1];
	logic [TAG_W-1:0]    c_best_tag  [SLOTS+1];

	cmt_ctl_t            cmt;
	logic [IDX_W-1:0]    cmt_idx;
	logic                out_free;
	logic                oob;
	logic [StatusW-1:0]  r_status;
	logic [IDX_W-1:0]    r_idx;
	logic                r_wbv;
	logic [TAG_W-1:0]    r_wbb;
	logic [IDX_W:0]      idx_ext;
	logic [BlkW:0]       tag_ext;
	logic [SlotIdxW-1:0] r_slot;
	logic [WbBlkW-1:0]   r_wb_blk;

	// Inject the held request at the head of the chain
	assign c_blk[0]       = blk_q[TAG_W-1:0];
	assign c_flags[0]     = '0;
	assign c_match_idx[0] = '0;
	assign c_free_idx[0]  = '0;
	assign c_best_idx[0]  = '0;
	assign c_best_age[0]  = '0;
	assign c_best_tag[0]  = '0;

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		lbpm_cell #(
			.CELL_IDX (g),
			.IDX_W    (IDX_W),
			.TAG_W    (TAG_W),
			.AGE_BITS (AGE_BITS)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.blk_in        (c_blk[g]),
			.flags_in      (c_flags[g]),
			.match_idx_in  (c_match_idx[g]),
			.free_idx_in   (c_free_idx[g]),
			.best_idx_in   (c_best_idx[g]),
			.best_age_in   (c_best_age[g]),
			.best_tag_in   (c_best_tag[g]),
			.blk_out       (c_blk[g+1]),
			.flags_out     (c_flags[g+1]),
			.match_idx_out (c_match_idx[g+1]),
			.free_idx_out  (c_free_idx[g+1]),
			.best_idx_out  (c_best_idx[g+1]),
			.best_age_out  (c_best_age[g+1]),
			.best_tag_out  (c_best_tag[g+1]),
			.cmt           (cmt),
			.cmt_idx       (cmt_idx),
			.cmt_tag       (blk_q[TAG_W-1:0])
		);
	end

	assign out_free = !out_valid_q || m_tready;
	assign oob      = {1'b0, blk_q} >= (BlkW+1)'(DISK_SIZE);

	// Decide the result from the item that left the last cell
	always_comb begin
		r_status = ST_OK;
		r_idx    = '0;
		r_wbv    = 1'b0;
		r_wbb    = '0;
		cmt      = '0;
		cmt_idx  = '0;
		if (op_q == OP_UNUSED) begin
			r_status = ST_MISS;
		end else if (oob) begin
			r_status = ST_OOB;
		end else begin
			case (op_q)
				OP_ALLOC: begin
					cmt.age_all = 1'b1;
					cmt.install = 1'b1;
					if (c_flags[SLOTS].free_found) begin
						cmt_idx = c_free_idx[SLOTS];
					end else begin
						cmt_idx = c_best_idx[SLOTS];
						r_wbv   = c_flags[SLOTS].best_dirty;
						r_wbb   = c_flags[SLOTS].best_dirty ? c_best_tag[SLOTS] : '0;
					end
					r_idx = cmt_idx;
				end
				OP_LOOKUP: begin
					if (c_flags[SLOTS].match_found) begin
						r_idx = c_match_idx[SLOTS];
					end else begin
						r_status = ST_MISS;
					end
				end
				OP_DIRTY: begin
					if (c_flags[SLOTS].match_found) begin
						cmt.mark = 1'b1;
						cmt_idx  = c_match_idx[SLOTS];
					end else begin
						r_status = ST_MISS;
					end
				end
				default: begin
					r_status = ST_MISS;
				end
			endcase
		end
		// Only update the slots in the one cycle the result is stored
		if (!(state_q == S_COMMIT && out_free)) begin
			cmt = '0;
		end
	end

	// Fit slot number and tag into their output fields
	assign idx_ext  = {1'b0, r_idx};
	assign tag_ext  = (BlkW+1)'(r_wbb);
	assign r_slot   = SlotIdxW'(idx_ext);
	assign r_wb_blk = tag_ext[WbBlkW-1:0];

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Sequence one request through search and update; hold the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			op_q        <= '0;
			blk_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (out_valid_q && m_tready && (state_q != S_COMMIT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tuser;
						blk_q   <= s_tdata[BlkW-1:0];
						cnt_q   <= '0;
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (cnt_q == IDX_W'(SLOTS - 1)) begin
						state_q <= S_COMMIT;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				S_COMMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {3'b000, r_wb_blk, r_wbv, r_slot, r_status};
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* test/testbench.sv */
// Self-checking testbench for the LRU buffer pool manager unit.
module testbench;
	import lbpm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_WAIT  = 2 * SlotsDef + 10;
	localparam int unsigned POOL_SPREAD = 47;

	localparam logic [AgeBitsDef-1:0] AGE_MAX = '1;

	typedef struct packed {
		logic [StatusW-1:0]  status;
		logic [SlotIdxW-1:0] slot;
		logic                wb_valid;
		logic [WbBlkW-1:0]   wb_block;
	} pool_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // [13:0] block_number
	logic [1:0]  s_tuser = '0;   // [1:0] operation
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // [1:0] status, [6:2] slot_index,
	                             // [7] writeback_valid, [20:8] writeback_block

	// Shadow copy of the slot table
	logic                  slot_used  [SlotsDef];
	logic                  slot_dirty [SlotsDef];
	logic [WbBlkW-1:0]     slot_block [SlotsDef];
	logic [AgeBitsDef-1:0] slot_age   [SlotsDef];

	pool_result_t pending_results[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned cycle_count   = 0;
	int unsigned mismatches    = 0;
	int unsigned results_seen  = 0;
	int unsigned n_requests    = 0;
	int unsigned n_alloc       = 0;
	int unsigned n_writeback   = 0;
	int unsigned n_hit         = 0;
	int unsigned n_miss        = 0;
	int unsigned n_oob         = 0;

	lru_buffer_pool_manager_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// Abort a run that has stopped making progress
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	// Stall the result side at random
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		$display("ERROR result %0d: %s got %0d expected %0d", results_seen, what, got, want);
		mismatches++;
	endtask

	// Apply one request to the shadow table and return the result it should give
	function automatic pool_result_t predict_request(input logic [OpW-1:0] op,
		input logic [BlkW-1:0] blk);
		pool_result_t  res;
		int            victim;
		int            holder;
		logic [AgeBitsDef-1:0] oldest;
		res    = '0;
		victim = -1;
		holder = -1;
		if (op == OP_UNUSED) begin
			res.status = ST_MISS;
			n_miss++;
		end else if (blk >= DiskSizeDef) begin
			res.status = ST_OOB;
			n_oob++;
		end else if (op == OP_ALLOC) begin
			n_alloc++;
			// age occupied slots, saturating
			for (int i = 0; i < SlotsDef; i++)
				if (slot_used[i] && slot_age[i] != AGE_MAX)
					slot_age[i]++;
			for (int i = 0; i < SlotsDef; i++)
				if (!slot_used[i] && victim < 0)
					victim = i;
			// no free slot: evict the lowest-numbered oldest one
			if (victim < 0) begin
				victim = 0;
				oldest = slot_age[0];
				for (int i = 1; i < SlotsDef; i++) begin
					if (slot_age[i] > oldest) begin
						oldest = slot_age[i];
						victim = i;
					end
				end
				if (slot_dirty[victim]) begin
					res.wb_valid = 1'b1;
					res.wb_block = slot_block[victim];
					n_writeback++;
				end
			end
			slot_used[victim]  = 1'b1;
			slot_dirty[victim] = 1'b0;
			slot_block[victim] = blk[WbBlkW-1:0];
			slot_age[victim]   = '0;
			res.slot = victim[SlotIdxW-1:0];
		end else begin
			for (int i = 0; i < SlotsDef; i++)
				if (holder < 0 && slot_used[i] && slot_block[i] == blk[WbBlkW-1:0])
					holder = i;
			if (holder < 0) begin
				res.status = ST_MISS;
				n_miss++;
			end else begin
				n_hit++;
				if (op == OP_LOOKUP)
					res.slot = holder[SlotIdxW-1:0];
				else
					slot_dirty[holder] = 1'b1;
			end
		end
		return res;
	endfunction

	// Offer one item after a random gap and record its expected result once taken
	task automatic send_item(input logic [OpW-1:0] op, input logic [BlkW-1:0] blk);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, blk};
		do
			@(posedge clk);
		while (!s_tready);
		pending_results.push_back(predict_request(op, blk));
		n_requests++;
	endtask

	// Hold the request side idle until every expected result is back
	task automatic wait_for_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin : check_results
		pool_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending, status",
					32'(m_tdata[1:0]), 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[1:0] != want.status)
					report_mismatch("status", 32'(m_tdata[1:0]), 32'(want.status));
				if (m_tdata[6:2] != want.slot)
					report_mismatch("slot_index", 32'(m_tdata[6:2]), 32'(want.slot));
				if (m_tdata[7] != want.wb_valid)
					report_mismatch("writeback_valid", 32'(m_tdata[7]),
						32'(want.wb_valid));
				if (m_tdata[20:8] != want.wb_block)
					report_mismatch("writeback_block", 32'(m_tdata[20:8]),
						32'(want.wb_block));
			end
		end
	end

	// Edges of the block range, every operation, misses and out-of-bound requests
	task automatic test_request_edges();
		send_item(OP_LOOKUP, 14'd0);
		send_item(OP_DIRTY, 14'd0);
		send_item(OP_ALLOC, 14'd0);
		send_item(OP_ALLOC, 14'd8191);
		send_item(OP_LOOKUP, 14'd8191);
		send_item(OP_LOOKUP, 14'd0);
		send_item(OP_DIRTY, 14'd8191);
		send_item(OP_ALLOC, 14'd8192);
		send_item(OP_LOOKUP, 14'd16383);
		send_item(OP_DIRTY, 14'd8192);
		send_item(OP_ALLOC, 14'd16383);
		send_item(OP_UNUSED, 14'd0);
		send_item(OP_UNUSED, 14'd16383);
		// a second copy of a block: lookup must find the lower slot
		send_item(OP_ALLOC, 14'd0);
		send_item(OP_LOOKUP, 14'd0);
		send_item(OP_LOOKUP, 14'd1);
		send_item(OP_DIRTY, 14'd1);
	endtask

	// Mixed traffic over a small set of blocks so slots fill, hit and get evicted dirty
	task automatic test_pool_traffic(input int unsigned count, input int unsigned s_idle,
		input int unsigned r_idle);
		int unsigned      kind;
		int unsigned      pick;
		logic [OpW-1:0]   op;
		logic [BlkW-1:0]  blk;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(99);
			pick = $urandom_range(99);
			if (pick < 70)
				blk = BlkW'($urandom_range(POOL_SPREAD));
			else if (pick < 85)
				blk = 14'd8191 - BlkW'($urandom_range(15));
			else
				blk = BlkW'($urandom_range(16383));
			if (kind < 38) begin
				op = OP_ALLOC;
			end else if (kind < 63) begin
				op = OP_LOOKUP;
			end else if (kind < 83) begin
				op = OP_DIRTY;
			end else if (kind < 88) begin
				op = OP_UNUSED;
			end else begin
				op  = OpW'($urandom_range(2));
				blk = 14'd8192 + BlkW'($urandom_range(8191));
			end
			send_item(op, blk);
		end
	endtask

	initial begin
		for (int i = 0; i < SlotsDef; i++) begin
			slot_used[i]  = 1'b0;
			slot_dirty[i] = 1'b0;
			slot_block[i] = '0;
			slot_age[i]   = '0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 20;
		recv_idle_pct = 88;
		test_request_edges();
		wait_for_results();

		test_pool_traffic(300, 20, 88);
		wait_for_results();
		test_pool_traffic(300, 88, 20);
		wait_for_results();
		test_pool_traffic(300, 0, 0);
		wait_for_results();

		repeat (DRAIN_WAIT) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results still pending", pending_results.size(), 32'd0);

		$display("Sent %0d requests: %0d allocations, %0d dirty write-backs, %0d hits",
			n_requests, n_alloc, n_writeback, n_hit);
		$display("Also %0d misses and %0d out-of-bound requests; %0d results checked",
			n_miss, n_oob, results_seen);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
